/* rtl/euler_fly_camera_update_core_defines.svh */
// Assertion macros shared by the fly camera RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef EULER_FLY_CAMERA_UPDATE_CORE_DEFINES_SVH
`define EULER_FLY_CAMERA_UPDATE_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define EFC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/efc_pkg.sv */
// Shared types, codes and constants of the fly camera block.
// No dependencies; imported by every RTL module.
package efc_pkg;

    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int VEC_FRAC_BITS_DEF = 14;
    localparam int TABLE_LEN         = 24;
    localparam int IDX_W             = 5;
    localparam int YAW_TURN          = 23040;
    localparam int PITCH_LIMIT       = 5696;
    localparam int HOME_Z            = 3 * 65536;

    // binary angle = t * 2^32 / 23040, split as t*Q + (R*t + RND) / 45
    localparam int MAP_Q    = 186413;
    localparam int MAP_R    = 23;
    localparam int MAP_RND  = 22;
    localparam int RECIP_M  = 2982617;  // ceil(2^27 / 45)
    localparam int RECIP_SH = 27;

    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    typedef enum logic [1:0] {
        REQ_MOVE   = 2'd0,
        REQ_ROTATE = 2'd1,
        REQ_SET    = 2'd2,
        REQ_INIT   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        DIR_FWD   = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_BACK  = 2'd2,
        DIR_LEFT  = 2'd3
    } dir_t;

    localparam logic [1:0] REG_MOVE_SPEED  = 2'd0;
    localparam logic [1:0] REG_START_YAW   = 2'd1;
    localparam logic [1:0] REG_START_PITCH = 2'd2;

    typedef struct packed {
        logic [20:0]        move_speed;
        logic [14:0]        start_yaw;
        logic signed [13:0] start_pitch;
    } cfg_t;

    typedef struct packed {
        logic       accept;
        logic       cord_start;
        logic       cord_take;
        logic       mul;
        logic       acc;
        logic       is_move;
        logic [1:0] k;
        logic       load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic cord_done;
    } dp_status_t;

    // arctan(2^-i), 2^32 per turn
    function automatic logic [31:0] atan_angle(input logic [IDX_W-1:0] i);
        logic [31:0] a;
        unique case (i)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

/* rtl/efc_cordic.sv */
// Iterative sine/cosine unit, one CORDIC step per cycle.
// Depends on efc_pkg.
module efc_cordic #(
    parameter int STEPS = efc_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC  = efc_pkg::VEC_FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [15:0]       angle,
    output logic                     done,
    output logic signed [FRAC+1:0]   cos_val,
    output logic signed [FRAC+1:0]   sin_val
);
    import efc_pkg::*;

    localparam int VW = FRAC + 2;
    localparam int SH = 30 - FRAC;
    localparam logic signed [33:0] ONE  = 34'sd1 <<< FRAC;
    localparam logic signed [33:0] RND  = 34'sd1 <<< (SH - 1);
    localparam logic signed [33:0] QTR  = 34'sd1 <<< 30;
    localparam logic signed [33:0] HALF = 34'sd1 <<< 31;

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_MAP1 = 6'b000010,
        PH_MAP2 = 6'b000100,
        PH_MAP3 = 6'b001000,
        PH_ROT  = 6'b010000,
        PH_FIN  = 6'b100000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic               done_reg;
    logic [14:0]        t_reg;
    logic [31:0]        p1_reg;
    logic [19:0]        v_reg;
    logic [14:0]        q_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic [IDX_W-1:0]   i_reg;
    logic               flip_reg;
    logic signed [VW-1:0] cos_reg, sin_reg;

    logic signed [16:0] wa;
    logic [32:0]        p1_full;
    logic [41:0]        q_full;
    logic [31:0]        bang;
    logic signed [33:0] zs, z0;
    logic               flip0;
    logic signed [33:0] dx, dy, at;
    logic signed [33:0] xf, yf, xr, yr, xc, yc;

    always_comb
    begin
        wa      = 17'(angle) + (angle[15] ? 17'sd23040 : 17'sd0);
        p1_full = 33'(t_reg) * 33'(MAP_Q);
        q_full  = 42'(v_reg) * 42'(RECIP_M);
        bang    = p1_reg + 32'(q_reg);
        zs      = 34'(signed'(bang));
        flip0   = (zs > QTR) || (zs < -QTR);
        if (!flip0)
            z0 = zs;
        else if (zs > 34'sd0)
            z0 = zs - HALF;
        else
            z0 = zs + HALF;
        dx = y_reg >>> i_reg;
        dy = x_reg >>> i_reg;
        at = 34'(atan_angle(i_reg));
        xf = flip_reg ? -x_reg : x_reg;
        yf = flip_reg ? -y_reg : y_reg;
        xr = (xf + RND) >>> SH;
        yr = (yf + RND) >>> SH;
        xc = (xr > ONE) ? ONE : ((xr < -ONE) ? -ONE : xr);
        yc = (yr > ONE) ? ONE : ((yr < -ONE) ? -ONE : yr);
    end

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE: if (start) phase_next = PH_MAP1;
            PH_MAP1: phase_next = PH_MAP2;
            PH_MAP2: phase_next = PH_MAP3;
            PH_MAP3: phase_next = PH_ROT;
            PH_ROT:  if (i_reg == IDX_W'(STEPS - 1)) phase_next = PH_FIN;
            PH_FIN:  phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == PH_FIN);
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && start)
            t_reg <= wa[14:0];
        if (phase_reg == PH_MAP1)
        begin
            p1_reg <= p1_full[31:0];
            v_reg  <= 20'(t_reg) * 20'(MAP_R) + 20'(MAP_RND);
        end
        if (phase_reg == PH_MAP2)
            q_reg <= q_full[RECIP_SH+14:RECIP_SH];
        if (phase_reg == PH_MAP3)
        begin
            x_reg    <= CORDIC_X0;
            y_reg    <= 34'sd0;
            z_reg    <= z0;
            flip_reg <= flip0;
            i_reg    <= '0;
        end
        if (phase_reg == PH_ROT)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
            i_reg <= i_reg + 1'b1;
        end
        if (phase_reg == PH_FIN)
        begin
            cos_reg <= VW'(xc);
            sin_reg <= VW'(yc);
        end
    end

    assign done    = done_reg;
    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

/* rtl/efc_dp.sv */
// Datapath: pose state, two CORDIC lanes, shared multiplier, result register.
// Depends on efc_pkg and efc_cordic.
module efc_dp #(
    parameter int CORDIC_STEPS  = efc_pkg::CORDIC_STEPS_DEF,
    parameter int VEC_FRAC_BITS = efc_pkg::VEC_FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  efc_pkg::dp_cmd_t    cmd,
    output efc_pkg::dp_status_t status,
    input  efc_pkg::cfg_t       cfg,
    input  logic [1:0]          req_type,
    input  logic [1:0]          direction,
    input  logic signed [13:0]  rot_speed,
    input  logic signed [31:0]  new_pos_x,
    input  logic signed [31:0]  new_pos_y,
    input  logic signed [31:0]  new_pos_z,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic signed [31:0]  pos_z,
    output logic signed [15:0]  front_x,
    output logic signed [15:0]  front_y,
    output logic signed [15:0]  front_z,
    output logic signed [15:0]  right_x,
    output logic signed [15:0]  right_y,
    output logic signed [15:0]  right_z,
    output logic signed [15:0]  up_x,
    output logic signed [15:0]  up_y,
    output logic signed [15:0]  up_z
);
    import efc_pkg::*;

    localparam int VW  = VEC_FRAC_BITS + 2;
    localparam int OPW = (VW > 22) ? VW : 22;
    localparam int PW  = 2 * OPW;
    localparam int EW  = (VW > 16) ? VW : 16;
    localparam logic signed [PW-1:0] PRND = PW'(1) <<< (VEC_FRAC_BITS - 1);
    localparam logic signed [33:0] POS_MAX = 34'sd2147483647;
    localparam logic signed [33:0] POS_MIN = -34'sd2147483648;

    logic signed [31:0]   pos_reg [3];
    logic [14:0]          yaw_reg;
    logic signed [13:0]   pitch_reg;
    logic [1:0]           dir_reg;
    logic signed [VW-1:0] front_reg [3];
    logic signed [VW-1:0] up_reg [3];
    logic signed [VW-1:0] right_x_reg, right_z_reg;
    logic signed [VW-1:0] cy_reg, sy_reg, cp_reg, sp_reg;
    logic signed [PW-1:0] prod_reg;

    logic signed [31:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [15:0] fx_reg, fy_reg, fz_reg, rx_reg, rz_reg, ux_reg, uy_reg, uz_reg;

    logic                 c0_done, c1_done;
    logic signed [VW-1:0] c0_cos, c0_sin, c1_cos, c1_sin;

    logic signed [15:0]   rs16, pitch_sum, yaw_sum, pitch_clamped, yaw_wrapped;
    logic [14:0]          init_yaw;
    logic signed [13:0]   init_pitch;
    logic signed [VW-1:0] vsel;
    logic signed [OPW-1:0] op_a, op_b;
    logic signed [PW-1:0] rnd;
    logic signed [33:0]   delta, psum, psat;
    logic signed [VW-1:0] rv;

    function automatic logic [15:0] to_field(input logic signed [VW-1:0] v);
        logic signed [EW-1:0] e;
        e = EW'(v);
        return e[15:0];
    endfunction

    efc_cordic #(.STEPS(CORDIC_STEPS), .FRAC(VEC_FRAC_BITS)) u_cordic_yaw (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.cord_start),
        .angle   (16'(signed'({1'b0, yaw_reg}))),
        .done    (c0_done),
        .cos_val (c0_cos),
        .sin_val (c0_sin)
    );

    efc_cordic #(.STEPS(CORDIC_STEPS), .FRAC(VEC_FRAC_BITS)) u_cordic_pitch (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.cord_start),
        .angle   (16'(pitch_reg)),
        .done    (c1_done),
        .cos_val (c1_cos),
        .sin_val (c1_sin)
    );

    assign status.cord_done = c0_done && c1_done;

    // angle updates
    always_comb
    begin
        rs16      = 16'(rot_speed);
        pitch_sum = 16'(pitch_reg) + ((direction == DIR_BACK) ? -rs16 : rs16);
        yaw_sum   = 16'(signed'({1'b0, yaw_reg})) + ((direction == DIR_LEFT) ? -rs16 : rs16);
        if (pitch_sum > 16'sd5696)
            pitch_clamped = 16'sd5696;
        else if (pitch_sum < -16'sd5696)
            pitch_clamped = -16'sd5696;
        else
            pitch_clamped = pitch_sum;
        if (yaw_sum < 16'sd0)
            yaw_wrapped = yaw_sum + 16'sd23040;
        else if (yaw_sum >= 16'sd23040)
            yaw_wrapped = yaw_sum - 16'sd23040;
        else
            yaw_wrapped = yaw_sum;
        init_yaw = (cfg.start_yaw >= 15'(YAW_TURN)) ? cfg.start_yaw - 15'(YAW_TURN)
                                                    : cfg.start_yaw;
        if (cfg.start_pitch > 14'sd5696)
            init_pitch = 14'sd5696;
        else if (cfg.start_pitch < -14'sd5696)
            init_pitch = -14'sd5696;
        else
            init_pitch = cfg.start_pitch;
    end

    // multiplier operands
    always_comb
    begin
        unique case (cmd.k)
            2'd0:    vsel = dir_reg[0] ? right_x_reg : front_reg[0];
            2'd1:    vsel = dir_reg[0] ? '0 : front_reg[1];
            2'd2:    vsel = dir_reg[0] ? right_z_reg : front_reg[2];
            default: vsel = '0;
        endcase
        if (cmd.is_move)
        begin
            op_a = OPW'(signed'({1'b0, cfg.move_speed}));
            op_b = OPW'(vsel);
        end
        else
        begin
            op_a = cmd.k[0] ? OPW'(sy_reg) : OPW'(cy_reg);
            op_b = cmd.k[1] ? OPW'(sp_reg) : OPW'(cp_reg);
        end
        rnd   = (prod_reg + PRND) >>> VEC_FRAC_BITS;
        delta = 34'(rnd);
        rv    = VW'(rnd);
        psum  = dir_reg[1] ? 34'(pos_reg[cmd.k]) - delta : 34'(pos_reg[cmd.k]) + delta;
        if (psum > POS_MAX)
            psat = POS_MAX;
        else if (psum < POS_MIN)
            psat = POS_MIN;
        else
            psat = psum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg[0] <= 32'sd0;
            pos_reg[1] <= 32'sd0;
            pos_reg[2] <= 32'(HOME_Z);
            yaw_reg    <= '0;
            pitch_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            unique case (req_t'(req_type))
                REQ_ROTATE:
                begin
                    if (direction[0])
                        yaw_reg <= yaw_wrapped[14:0];
                    else
                        pitch_reg <= pitch_clamped[13:0];
                end
                REQ_SET:
                begin
                    pos_reg[0] <= new_pos_x;
                    pos_reg[1] <= new_pos_y;
                    pos_reg[2] <= new_pos_z;
                end
                REQ_INIT:
                begin
                    pos_reg[0] <= 32'sd0;
                    pos_reg[1] <= 32'sd0;
                    pos_reg[2] <= 32'(HOME_Z);
                    yaw_reg    <= init_yaw;
                    pitch_reg  <= init_pitch;
                end
                default: ;
            endcase
        end
        else if (cmd.acc && cmd.is_move)
            pos_reg[cmd.k] <= psat[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            dir_reg <= direction;
        if (cmd.cord_take)
        begin
            cy_reg       <= c0_cos;
            sy_reg       <= c0_sin;
            cp_reg       <= c1_cos;
            sp_reg       <= c1_sin;
            front_reg[1] <= c1_sin;
            right_x_reg  <= -c0_sin;
            right_z_reg  <= c0_cos;
            up_reg[1]    <= c1_cos;
        end
        if (cmd.mul)
            prod_reg <= op_a * op_b;
        if (cmd.acc && !cmd.is_move)
        begin
            unique case (cmd.k)
                2'd0:    front_reg[0] <= rv;
                2'd1:    front_reg[2] <= rv;
                2'd2:    up_reg[0]    <= -rv;
                default: up_reg[2]    <= -rv;
            endcase
        end
        if (cmd.load_out)
        begin
            pos_x_reg <= pos_reg[0];
            pos_y_reg <= pos_reg[1];
            pos_z_reg <= pos_reg[2];
            fx_reg    <= to_field(front_reg[0]);
            fy_reg    <= to_field(front_reg[1]);
            fz_reg    <= to_field(front_reg[2]);
            rx_reg    <= to_field(right_x_reg);
            rz_reg    <= to_field(right_z_reg);
            ux_reg    <= to_field(up_reg[0]);
            uy_reg    <= to_field(up_reg[1]);
            uz_reg    <= to_field(up_reg[2]);
        end
    end

    assign pos_x   = pos_x_reg;
    assign pos_y   = pos_y_reg;
    assign pos_z   = pos_z_reg;
    assign front_x = fx_reg;
    assign front_y = fy_reg;
    assign front_z = fz_reg;
    assign right_x = rx_reg;
    assign right_y = '0;
    assign right_z = rz_reg;
    assign up_x    = ux_reg;
    assign up_y    = uy_reg;
    assign up_z    = uz_reg;

endmodule

/* rtl/efc_ctrl.sv */
// Sequencer: input/output handshake and datapath command generation.
// Depends on efc_pkg and euler_fly_camera_update_core_defines.svh.
`include "euler_fly_camera_update_core_defines.svh"

module efc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          req_type,
    output logic                out_valid,
    input  logic                out_stall,
    output efc_pkg::dp_cmd_t    cmd,
    input  efc_pkg::dp_status_t status
);
    import efc_pkg::*;

    typedef enum logic [5:0] {
        ST_START = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_CORD  = 6'b000100,
        ST_MUL   = 6'b001000,
        ST_ACC   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic       boot_reg, boot_next;
    logic [1:0] k_reg, k_next;
    logic       move_reg, move_next;
    logic       out_valid_reg, out_valid_next;
    logic       last_k;

    assign in_stall = (state_reg != ST_IDLE);
    assign last_k   = move_reg ? (k_reg == 2'd2) : (k_reg == 2'd3);

    always_comb
    begin
        state_next   = state_reg;
        boot_next    = boot_reg;
        k_next       = k_reg;
        move_next    = move_reg;
        cmd          = '0;
        cmd.k        = k_reg;
        cmd.is_move  = move_reg;
        unique case (state_reg)
            ST_START:
            begin
                cmd.cord_start = 1'b1;
                state_next     = ST_CORD;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    k_next     = 2'd0;
                    unique case (req_t'(req_type))
                        REQ_MOVE:
                        begin
                            move_next  = 1'b1;
                            state_next = ST_MUL;
                        end
                        REQ_SET:  state_next = ST_OUT;
                        default:  state_next = ST_START;
                    endcase
                end
            end
            ST_CORD:
            begin
                if (status.cord_done)
                begin
                    cmd.cord_take = 1'b1;
                    k_next        = 2'd0;
                    move_next     = 1'b0;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (!last_k)
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_MUL;
                end
                else if (boot_reg)
                begin
                    boot_next  = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_START;
            boot_reg      <= 1'b1;
            k_reg         <= 2'd0;
            move_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            boot_reg      <= boot_next;
            k_reg         <= k_next;
            move_reg      <= move_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `EFC_ASSERT_NEXT(a_busy_after_accept, cmd.accept, in_stall, "accepted without going busy")
    `EFC_ASSERT_SAME(a_done_in_cord, status.cord_done, state_reg == ST_CORD, "cordic done out of step")
    `EFC_ASSERT_SAME(a_move_k_range, state_reg == ST_MUL && move_reg, k_reg != 2'd3, "move index overrun")
    `EFC_ASSERT_SAME(a_out_from_out, $rose(out_valid_reg), $past(state_reg == ST_OUT), "result without OUT state")

endmodule

/* rtl/euler_fly_camera_update_core.sv */
// Euler-angle fly camera. Keeps position (Q16.16), yaw/pitch (1/64 degree) and
// the front/right/up unit vectors (Q2.VEC_FRAC_BITS); each accepted request
// (move, rotate, set position, init) returns one transaction with the new pose.
// A set-position request goes straight to the output register, a move makes
// three passes through the shared multiplier, and a rotate or init is
// dominated by the two parallel CORDIC lanes that run one step per cycle.
// One request is in flight at a time; a finished result sits in the output
// register so the next request may be taken while it waits. After reset the
// block computes its initial vectors and holds in_stall high while it does so;
// configuration writes are taken meanwhile.
// Depends on efc_pkg, efc_ctrl, efc_dp.
module euler_fly_camera_update_core #(
    parameter int CORDIC_STEPS  = efc_pkg::CORDIC_STEPS_DEF,
    parameter int VEC_FRAC_BITS = efc_pkg::VEC_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // APB-style configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // request channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic [1:0]         direction,
    input  logic signed [13:0] rot_speed,
    input  logic signed [31:0] new_pos_x,
    input  logic signed [31:0] new_pos_y,
    input  logic signed [31:0] new_pos_z,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [15:0] front_x,
    output logic signed [15:0] front_y,
    output logic signed [15:0] front_z,
    output logic signed [15:0] right_x,
    output logic signed [15:0] right_y,
    output logic signed [15:0] right_z,
    output logic signed [15:0] up_x,
    output logic signed [15:0] up_y,
    output logic signed [15:0] up_z
);
    import efc_pkg::*;

    cfg_t       cfg_reg;
    dp_cmd_t    cmd;
    dp_status_t status;
    logic       wr_en;

    // registers sit at 4-byte strides
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.move_speed  <= 21'd3277;
            cfg_reg.start_yaw   <= 15'd17280;
            cfg_reg.start_pitch <= 14'sd0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_MOVE_SPEED:  cfg_reg.move_speed  <= pwdata[20:0];
                REG_START_YAW:   cfg_reg.start_yaw   <= pwdata[14:0];
                REG_START_PITCH: cfg_reg.start_pitch <= pwdata[13:0];
                default: ;  // unmapped: write dropped
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MOVE_SPEED:  prdata = 32'(cfg_reg.move_speed);
            REG_START_YAW:   prdata = 32'(cfg_reg.start_yaw);
            REG_START_PITCH: prdata = 32'(cfg_reg.start_pitch);
            default:         prdata = '0;
        endcase
    end

    efc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    efc_dp #(
        .CORDIC_STEPS  (CORDIC_STEPS),
        .VEC_FRAC_BITS (VEC_FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg       (cfg_reg),
        .req_type  (req_type),
        .direction (direction),
        .rot_speed (rot_speed),
        .new_pos_x (new_pos_x),
        .new_pos_y (new_pos_y),
        .new_pos_z (new_pos_z),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .front_x   (front_x),
        .front_y   (front_y),
        .front_z   (front_z),
        .right_x   (right_x),
        .right_y   (right_y),
        .right_z   (right_z),
        .up_x      (up_x),
        .up_y      (up_y),
        .up_z      (up_z)
    );

endmodule
